FILE: rtl/isa_pkg.sv
`default_nettype none

package isa_pkg;

  // Field and datapath widths
  localparam int QW       = 16;  // Q1.14 quaternion component
  localparam int PROD_W   = 35;  // Q.28 column entry before rounding
  localparam int COL_W    = 20;  // Q.14 column entry after rounding
  localparam int DOTP_W   = 2 * COL_W;
  localparam int DOT_W    = DOTP_W + 2;
  localparam int U_W      = 30;  // saturated dot product, Q.28
  localparam int ROOT_W   = 29;  // floor square root, Q.28
  localparam int SQN_W    = 2 * ROOT_W - 1;
  localparam int SQR_W    = 2 * ROOT_W;
  localparam int CX_W     = 33;  // CORDIC x and y
  localparam int ANG_W    = 24;  // angle in units of 2^-20 rad
  localparam int AOUT_W   = 16;

  localparam int TABLE_LEN     = 24;
  localparam int ARC_STEPS_DEF = 16;

  localparam longint ONE_Q28     = 64'sd268435456;
  localparam int      HALF_PI_U20 = 1647099;
  localparam int      PI_Q14      = 51472;

  // Queue between front and back
  localparam int QDEPTH = 4;  // power of two
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    REG_CAL_W,
    REG_CAL_X,
    REG_CAL_Y,
    REG_CAL_Z,
    REG_MOUNT
  } cfg_reg_e;

  typedef logic signed [COL_W-1:0] col_t;

  typedef struct packed {
    col_t c0;
    col_t c1;
    col_t c2;
  } column_t;

  // Calibration state handed from front to back
  typedef struct packed {
    column_t cal;
    logic    mount_back;
  } cal_t;

  // One classified word in the queue
  typedef struct packed {
    column_t col;
    logic    last;
  } item_t;

  // Round Q.28 to Q.14, half away from zero
  function automatic col_t round14(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] r;
    m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    r = (m + PROD_W'(8192)) >> 14;
    return v[PROD_W-1] ? -col_t'(r[COL_W-1:0]) : col_t'(r[COL_W-1:0]);
  endfunction

  // Third rotation-matrix column of a quaternion, Q.14 entries
  function automatic column_t third_col(input logic signed [QW-1:0] w,
                                        input logic signed [QW-1:0] x,
                                        input logic signed [QW-1:0] y,
                                        input logic signed [QW-1:0] z);
    logic signed [PROD_W-1:0] t0;
    logic signed [PROD_W-1:0] t1;
    logic signed [PROD_W-1:0] t2;
    column_t c;
    t0 = (PROD_W'(x) * PROD_W'(z) + PROD_W'(y) * PROD_W'(w)) <<< 1;
    t1 = (PROD_W'(y) * PROD_W'(z) - PROD_W'(x) * PROD_W'(w)) <<< 1;
    t2 = PROD_W'(ONE_Q28) - ((PROD_W'(x) * PROD_W'(x) + PROD_W'(y) * PROD_W'(y)) <<< 1);
    c.c0 = round14(t0);
    c.c1 = round14(t1);
    c.c2 = round14(t2);
    return c;
  endfunction

  // Arctangent of 2^-i in units of 2^-20 rad
  function automatic logic [19:0] atan_u20(input int unsigned i);
    logic [19:0] a;
    case (i)
      0:  a = 20'd823550;
      1:  a = 20'd486170;
      2:  a = 20'd256879;
      3:  a = 20'd130396;
      4:  a = 20'd65451;
      5:  a = 20'd32757;
      6:  a = 20'd16383;
      7:  a = 20'd8192;
      8:  a = 20'd4096;
      9:  a = 20'd2048;
      10: a = 20'd1024;
      11: a = 20'd512;
      12: a = 20'd256;
      13: a = 20'd128;
      14: a = 20'd64;
      15: a = 20'd32;
      16: a = 20'd16;
      17: a = 20'd8;
      18: a = 20'd4;
      19: a = 20'd2;
      20: a = 20'd1;
      21: a = 20'd1;
      default: a = 20'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/isa_if.sv
`default_nettype none

// Quaternion sample channel
interface isa_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cur_w;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic signed [15:0] cur_z;
  logic               sample_last;

  modport source (output valid, cur_w, cur_x, cur_y, cur_z, sample_last, input ready);
  modport sink   (input valid, cur_w, cur_x, cur_y, cur_z, sample_last, output ready);
endinterface

// Angle result channel
interface isa_angle_if;
  logic        valid;
  logic        ready;
  logic [15:0] sagittal_angle;
  logic        angle_last;

  modport source (output valid, sagittal_angle, angle_last, input ready);
  modport sink   (input valid, sagittal_angle, angle_last, output ready);
endinterface

// Configuration write channel
interface isa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/isa_front.sv
`default_nettype none

module isa_front import isa_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  isa_cfg_if.sink    cfg_i,
  isa_sample_if.sink sample_i,
  input  wire logic  full_i,
  output logic       push_o,
  output item_t      item_o,
  output cal_t       cal_o
);

  logic signed [QW-1:0] cal_w_q, cal_x_q, cal_y_q, cal_z_q;
  logic                 mount_q;
  column_t              cal_col_q;
  logic                 st_v_q;
  item_t                st_item_q;
  logic                 take;

  assign cfg_i.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_w_q <= QW'(16384);
      cal_x_q <= '0;
      cal_y_q <= '0;
      cal_z_q <= '0;
      mount_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_CAL_W: cal_w_q <= cfg_i.data;
        REG_CAL_X: cal_x_q <= cfg_i.data;
        REG_CAL_Y: cal_y_q <= cfg_i.data;
        REG_CAL_Z: cal_z_q <= cfg_i.data;
        REG_MOUNT: mount_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Track the calibration column
  always_ff @(posedge clk_i) begin
    cal_col_q <= third_col(cal_w_q, cal_x_q, cal_y_q, cal_z_q);
  end

  assign cal_o.cal        = cal_col_q;
  assign cal_o.mount_back = mount_q;

  // Input stage: hold one word until the queue has room
  assign sample_i.ready = !st_v_q || !full_i;
  assign take           = sample_i.valid && sample_i.ready;
  assign push_o         = st_v_q && !full_i;
  assign item_o         = st_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= 1'b0;
    end else if (sample_i.ready) begin
      st_v_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      st_item_q.col  <= third_col(sample_i.cur_w, sample_i.cur_x,
                                  sample_i.cur_y, sample_i.cur_z);
      st_item_q.last <= sample_i.sample_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/isa_fifo.sv
`default_nettype none

module isa_fifo import isa_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      item_o
);

  item_t          mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

`default_nettype wire

FILE: rtl/isa_back.sv
`default_nettype none

module isa_back import isa_pkg::*; #(
  parameter int unsigned ARC_STEPS = ARC_STEPS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cal_t   cal_i,
  input  wire item_t  item_i,
  input  wire logic   empty_i,
  output logic        pop_o,
  isa_angle_if.source angle_o
);

  localparam int NSTEPS = (ARC_STEPS > TABLE_LEN) ? TABLE_LEN : int'(ARC_STEPS);
  localparam int SQ_STAGES = ROOT_W;

  logic en;

  // Product stage
  logic                     a_v_q, a_last_q;
  logic signed [DOTP_W-1:0] p0_q, p1_q, p2_q;
  // Saturate stage
  logic                     b_v_q, b_last_q;
  logic signed [U_W-1:0]    b_u_q, b_u_d;
  logic [ROOT_W-1:0]        b_um_q, b_um_d;
  logic signed [DOT_W-1:0]  dot;
  logic signed [U_W-1:0]    dsat;
  // Square stage
  logic                     c_v_q, c_last_q;
  logic signed [U_W-1:0]    c_u_q;
  logic [SQN_W-1:0]         c_sq_q;
  logic [SQR_W-1:0]         sq_full;
  // Square-root pipeline
  logic                     s_v_q    [SQ_STAGES+1];
  logic                     s_last_q [SQ_STAGES+1];
  logic signed [U_W-1:0]    s_u_q    [SQ_STAGES+1];
  logic [SQN_W-1:0]         s_n_q    [SQ_STAGES+1];
  logic [SQR_W-1:0]         s_r_q    [SQ_STAGES+1];
  logic [SQN_W-1:0]         s_n_d    [SQ_STAGES];
  logic [SQR_W-1:0]         s_r_d    [SQ_STAGES];
  logic [SQR_W-1:0]         s_t      [SQ_STAGES];
  logic [SQR_W-1:0]         s_bit    [SQ_STAGES];
  // CORDIC pipeline
  logic                     k_v_q    [NSTEPS+1];
  logic                     k_last_q [NSTEPS+1];
  logic signed [CX_W-1:0]   k_x_q    [NSTEPS+1];
  logic signed [CX_W-1:0]   k_y_q    [NSTEPS+1];
  logic signed [ANG_W-1:0]  k_a_q    [NSTEPS+1];
  logic signed [CX_W-1:0]   k_x_d    [NSTEPS+1];
  logic signed [CX_W-1:0]   k_y_d    [NSTEPS+1];
  logic signed [ANG_W-1:0]  k_a_d    [NSTEPS+1];
  logic signed [CX_W-1:0]   root_x;
  // Output register
  logic                     out_v_q, out_last_q;
  logic [AOUT_W-1:0]        out_ang_q, out_ang_d;
  logic [ANG_W-1:0]         rnd;

  // Whole pipeline moves when the output register can take a word
  assign en    = !out_v_q || angle_o.ready;
  assign pop_o = en && !empty_i;

  // Dot product, saturation and mounting side
  always_comb begin
    dot = DOT_W'(p0_q) + DOT_W'(p1_q) + DOT_W'(p2_q);
    if (dot > DOT_W'(ONE_Q28))       dsat = U_W'(ONE_Q28);
    else if (dot < -DOT_W'(ONE_Q28)) dsat = -U_W'(ONE_Q28);
    else                             dsat = dot[U_W-1:0];
    b_u_d  = cal_i.mount_back ? dsat : -dsat;
    b_um_d = b_u_d[U_W-1] ? ROOT_W'(-b_u_d) : ROOT_W'(b_u_d);
  end

  assign sq_full = b_um_q * b_um_q;

  // One result bit per square-root stage
  always_comb begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      s_bit[k] = SQR_W'(1) << (2 * (SQ_STAGES - 1 - k));
      s_t[k]   = s_r_q[k] + s_bit[k];
      if ({1'b0, s_n_q[k]} >= s_t[k]) begin
        s_n_d[k] = s_n_q[k] - s_t[k][SQN_W-1:0];
        s_r_d[k] = (s_r_q[k] >> 1) + s_bit[k];
      end else begin
        s_n_d[k] = s_n_q[k];
        s_r_d[k] = s_r_q[k] >> 1;
      end
    end
  end

  // Quadrant turn, then one CORDIC micro-rotation per stage
  always_comb begin
    root_x = CX_W'(s_r_q[SQ_STAGES][ROOT_W-1:0]);
    if (s_u_q[SQ_STAGES][U_W-1]) begin
      k_x_d[0] = root_x;
      k_y_d[0] = -CX_W'(s_u_q[SQ_STAGES]);
      k_a_d[0] = ANG_W'(HALF_PI_U20);
    end else begin
      k_x_d[0] = CX_W'(s_u_q[SQ_STAGES]);
      k_y_d[0] = root_x;
      k_a_d[0] = '0;
    end
    for (int i = 0; i < NSTEPS; i++) begin
      if (!k_y_q[i][CX_W-1] && (k_y_q[i] != '0)) begin
        k_x_d[i+1] = k_x_q[i] + (k_y_q[i] >>> i);
        k_y_d[i+1] = k_y_q[i] - (k_x_q[i] >>> i);
        k_a_d[i+1] = k_a_q[i] + $signed(ANG_W'(atan_u20(i)));
      end else begin
        k_x_d[i+1] = k_x_q[i] - (k_y_q[i] >>> i);
        k_y_d[i+1] = k_y_q[i] + (k_x_q[i] >>> i);
        k_a_d[i+1] = k_a_q[i] - $signed(ANG_W'(atan_u20(i)));
      end
    end
  end

  // Round to Q2.14 and clamp to the range 0..pi
  always_comb begin
    rnd = ANG_W'(k_a_q[NSTEPS] + ANG_W'(32)) >> 6;
    if (k_a_q[NSTEPS] <= 0)                   out_ang_d = '0;
    else if (rnd > ANG_W'(PI_Q14))            out_ang_d = AOUT_W'(PI_Q14);
    else                                      out_ang_d = rnd[AOUT_W-1:0];
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k <= SQ_STAGES; k++) s_v_q[k] <= 1'b0;
      for (int i = 0; i <= NSTEPS; i++)    k_v_q[i] <= 1'b0;
    end else if (en) begin
      a_v_q    <= !empty_i;
      b_v_q    <= a_v_q;
      c_v_q    <= b_v_q;
      s_v_q[0] <= c_v_q;
      for (int k = 0; k < SQ_STAGES; k++) s_v_q[k+1] <= s_v_q[k];
      k_v_q[0] <= s_v_q[SQ_STAGES];
      for (int i = 0; i < NSTEPS; i++)    k_v_q[i+1] <= k_v_q[i];
      out_v_q  <= k_v_q[NSTEPS];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q     <= item_i.col.c0 * cal_i.cal.c0;
      p1_q     <= item_i.col.c1 * cal_i.cal.c1;
      p2_q     <= item_i.col.c2 * cal_i.cal.c2;
      a_last_q <= item_i.last;

      b_u_q    <= b_u_d;
      b_um_q   <= b_um_d;
      b_last_q <= a_last_q;

      c_u_q    <= b_u_q;
      c_sq_q   <= sq_full[SQN_W-1:0];
      c_last_q <= b_last_q;

      s_n_q[0]    <= (SQN_W'(1) << (SQN_W - 1)) - c_sq_q;
      s_r_q[0]    <= '0;
      s_u_q[0]    <= c_u_q;
      s_last_q[0] <= c_last_q;
      for (int k = 0; k < SQ_STAGES; k++) begin
        s_n_q[k+1]    <= s_n_d[k];
        s_r_q[k+1]    <= s_r_d[k];
        s_u_q[k+1]    <= s_u_q[k];
        s_last_q[k+1] <= s_last_q[k];
      end

      for (int i = 0; i <= NSTEPS; i++) begin
        k_x_q[i] <= k_x_d[i];
        k_y_q[i] <= k_y_d[i];
        k_a_q[i] <= k_a_d[i];
      end
      k_last_q[0] <= s_last_q[SQ_STAGES];
      for (int i = 0; i < NSTEPS; i++) k_last_q[i+1] <= k_last_q[i];

      out_ang_q  <= out_ang_d;
      out_last_q <= k_last_q[NSTEPS];
    end
  end

  assign angle_o.valid          = out_v_q;
  assign angle_o.sagittal_angle = out_ang_q;
  assign angle_o.angle_last     = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/imu_sagittal_angle_core.sv
// Sagittal angle of one body segment from an orientation quaternion.
//
// Channels: sample_i takes one Q1.14 quaternion word per cycle while ready
// (cur_w..cur_z plus sample_last); angle_o returns one unsigned Q2.14 angle
// in radians per sample, in order, with angle_last copied from sample_last.
// cfg_i writes the calibration quaternion (index 0..3) and the mounting side
// (index 4); write only while no sample is in flight. cfg_i is always ready.
//
// Throughput: one sample per cycle while sample_i.ready is high. The front
// stage forms the sample's rotation column and drops it into a 4-word queue;
// the back pipeline does the dot product, an integer square root of one bit
// per stage (29 stages) and a CORDIC arctangent of one micro-rotation per
// stage (ARC_STEPS stages, at most 24).
//
// Reset clears all valid bits and the queue, and loads the identity
// calibration with a front-mounted sensor. When angle_o stalls, the back
// pipeline holds; the queue and the front stage keep taking samples until
// they fill, then sample_i.ready drops.

`default_nettype none

module imu_sagittal_angle_core import isa_pkg::*; #(
  parameter int unsigned ARC_STEPS = ARC_STEPS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  isa_cfg_if.sink     cfg_i,
  isa_sample_if.sink  sample_i,
  isa_angle_if.source angle_o
);

  logic  push, full, pop, empty;
  item_t push_item, pop_item;
  cal_t  cal;

  isa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .sample_i (sample_i),
    .full_i   (full),
    .push_o   (push),
    .item_o   (push_item),
    .cal_o    (cal)
  );

  isa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  isa_back #(
    .ARC_STEPS (ARC_STEPS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cal_i   (cal),
    .item_i  (pop_item),
    .empty_i (empty),
    .pop_o   (pop),
    .angle_o (angle_o)
  );

endmodule

`default_nettype wire

FILE: sim/tb_imu_sagittal_angle_core.sv
`default_nettype none

module tb_imu_sagittal_angle_core;
  import isa_pkg::*;

  // Sample word as offered to the block
  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
  } quat_word_t;

  // Expected angle word
  typedef struct {
    logic [15:0] angle;
    logic        last;
  } angle_word_t;

  // Predicts the sagittal angle of each sample and holds pending results
  class angle_scoreboard;
    longint      cal_w = 16384, cal_x = 0, cal_y = 0, cal_z = 0;
    bit          mount_back = 0;
    angle_word_t pending[$];
    int          errors = 0;

    function void write_reg(cfg_reg_e idx, logic [15:0] data);
      case (idx)
        REG_CAL_W: cal_w = longint'($signed(data));
        REG_CAL_X: cal_x = longint'($signed(data));
        REG_CAL_Y: cal_y = longint'($signed(data));
        REG_CAL_Z: cal_z = longint'($signed(data));
        REG_MOUNT: mount_back = data[0];
        default: ;
      endcase
    endfunction

    function longint half_round(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + 8192) >>> 14;
      return (v < 0) ? -m : m;
    endfunction

    // Floor division by 2^s
    function longint down_shift(longint v, int s);
      return v >>> s;
    endfunction

    function longint floor_root(longint n);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >>> 1) + bitv;
        end else begin
          res = res >>> 1;
        end
        bitv = bitv >>> 2;
      end
      return res;
    endfunction

    function longint arc_table(int i);
      longint t[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1, 0, 0};
      return t[i];
    endfunction

    function longint arc_cos(longint u);
      longint um, cx, cy, acc, t, xs, ys;
      int steps;
      um = (u < 0) ? -u : u;
      cx = u;
      cy = floor_root((64'sd1 <<< 56) - um * um);
      acc = 0;
      steps = (ARC_STEPS_DEF > 24) ? 24 : ARC_STEPS_DEF;
      if (cx < 0) begin
        t = cx;
        cx = cy;
        cy = -t;
        acc = HALF_PI_U20;
      end
      for (int i = 0; i < steps; i++) begin
        xs = down_shift(cx, i);
        ys = down_shift(cy, i);
        if (cy > 0) begin
          cx += ys; cy -= xs; acc += arc_table(i);
        end else begin
          cx -= ys; cy += xs; acc -= arc_table(i);
        end
      end
      return acc;
    endfunction

    function void column(longint w, longint x, longint y, longint z, output longint c[3]);
      c[0] = half_round(2 * (x * z + y * w));
      c[1] = half_round(2 * (y * z - x * w));
      c[2] = half_round((64'sd1 <<< 28) - 2 * (x * x + y * y));
    endfunction

    // Note an accepted sample
    function void note_sample(quat_word_t s);
      longint ca[3], cb[3];
      longint d, a, r;
      angle_word_t e;
      column(cal_w, cal_x, cal_y, cal_z, ca);
      column(s.w, s.x, s.y, s.z, cb);
      d = ca[0] * cb[0] + ca[1] * cb[1] + ca[2] * cb[2];
      if (d > ONE_Q28) d = ONE_Q28;
      if (d < -ONE_Q28) d = -ONE_Q28;
      a = arc_cos(mount_back ? d : -d);
      r = (a <= 0) ? 0 : ((a + 32) >>> 6);
      if (r > PI_Q14) r = PI_Q14;
      e.angle = r[15:0];
      e.last = s.last;
      pending = {pending, e};
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH %0t: %s", $realtime, msg);
    endtask

    // Check an accepted angle word
    task check_angle(logic [15:0] angle, logic last);
      angle_word_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected angle %0d", angle));
        return;
      end
      e = pending.pop_front();
      if (angle !== e.angle)
        report($sformatf("angle got %0d want %0d", angle, e.angle));
      if (last !== e.last)
        report($sformatf("angle_last got %0b want %0b", last, e.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  isa_cfg_if    cfg_ch();
  isa_sample_if sample_ch();
  isa_angle_if  angle_ch();

  imu_sagittal_angle_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_ch.sink),
    .sample_i(sample_ch.sink),
    .angle_o (angle_ch.source)
  );

  angle_scoreboard sb = new();
  bit   calm_phase = 0;
  int   hold_cycles = 0;

  always #10 clk_i = ~clk_i;

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = 3'd0;
    cfg_ch.data = 16'd0;
    sample_ch.valid = 1'b0;
    sample_ch.cur_w = '0;
    sample_ch.cur_x = '0;
    sample_ch.cur_y = '0;
    sample_ch.cur_z = '0;
    sample_ch.sample_last = 1'b0;
    angle_ch.ready = 1'b0;
  end

  // Drive receiver ready with random stall bursts, or a long hold on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        angle_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 18);
        angle_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        angle_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Check each accepted angle word
  always @(posedge clk_i) begin
    if (rst_ni && angle_ch.valid && angle_ch.ready)
      sb.check_angle(angle_ch.sagittal_angle, angle_ch.angle_last);
  end

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_cal(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                         logic [15:0] z, logic mb);
    write_reg(REG_CAL_W, w);
    write_reg(REG_CAL_X, x);
    write_reg(REG_CAL_Y, y);
    write_reg(REG_CAL_Z, z);
    write_reg(REG_MOUNT, {15'd0, mb});
    @(posedge clk_i);
  endtask

  // Offer one sample word, with an optional idle burst before it
  task automatic send_sample(quat_word_t s, bit may_idle = 1);
    int n;
    if (may_idle && !calm_phase && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 18);
      sample_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.cur_w <= s.w;
    sample_ch.cur_x <= s.x;
    sample_ch.cur_y <= s.y;
    sample_ch.cur_z <= s.z;
    sample_ch.sample_last <= s.last;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    sb.note_sample(s);
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (ARC_STEPS_DEF + 45) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($signed($urandom_range(0, 32768)) - 16384);
      1: return 16'($urandom);
      2: return 16'sd16384;
      3: return -16'sd16384;
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  // Random unit-ish quaternion from a scaled random direction
  function automatic quat_word_t rand_unit();
    quat_word_t s;
    real a, b, c, d, n;
    a = $signed($urandom_range(0, 2000)) - 1000;
    b = $signed($urandom_range(0, 2000)) - 1000;
    c = $signed($urandom_range(0, 2000)) - 1000;
    d = $signed($urandom_range(0, 2000)) - 1000;
    n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
    s.w = 16'($rtoi(a / n * 16384.0));
    s.x = 16'($rtoi(b / n * 16384.0));
    s.y = 16'($rtoi(c / n * 16384.0));
    s.z = 16'($rtoi(d / n * 16384.0));
    s.last = 1'($urandom_range(0, 1));
    return s;
  endfunction

  function automatic quat_word_t mk(int w, int x, int y, int z, bit l);
    quat_word_t s;
    s.w = 16'(w); s.x = 16'(x); s.y = 16'(y); s.z = 16'(z); s.last = l;
    return s;
  endfunction

  initial begin
    quat_word_t s;
    int k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity calibration, extremes, non-unit and raw patterns
    send_sample(mk(16384, 0, 0, 0, 0));
    send_sample(mk(-16384, 0, 0, 0, 1));
    send_sample(mk(0, 16384, 0, 0, 0));
    send_sample(mk(0, 0, 16384, 0, 1));
    send_sample(mk(0, 0, 0, 16384, 0));
    send_sample(mk(11585, 11585, 0, 0, 0));
    send_sample(mk(11585, 0, 11585, 0, 1));
    send_sample(mk(11585, 0, -11585, 0, 0));
    send_sample(mk(0, 0, 0, 0, 0));
    send_sample(mk(32767, 32767, 32767, 32767, 1));
    send_sample(mk(-32768, -32768, -32768, -32768, 0));
    send_sample(mk(16384, 16384, 16384, 16384, 1));
    send_sample(mk(1, -1, 1, -1, 0));
    drain();

    // Back-mounted, identity calibration, four more samples
    set_cal(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_sample(mk(16384, 0, 0, 0, 1));
    send_sample(mk(0, 16384, 0, 0, 0));
    send_sample(mk(11585, 0, 11585, 0, 0));
    send_sample(mk(-32768, 32767, -32768, 32767, 1));
    drain();

    // Random phases over several calibrations, extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_cal(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 1'b0);
        1: set_cal(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1);
        2: set_cal(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        default: begin
          s = rand_unit();
          if ($urandom_range(0, 3) == 0) s = mk(rand_comp(), rand_comp(), rand_comp(),
                                                  rand_comp(), 0);
          set_cal(s.w, s.x, s.y, s.z, 1'($urandom_range(0, 1)));
        end
      endcase
      if (ph == 7) calm_phase = 1;
      for (k = 0; k < 135; k++) begin
        // Hold off the receiver long enough to back up the pipeline
        if (ph == 3 && k == 20) hold_cycles = 150;
        if ($urandom_range(0, 3) == 0) begin
          s = mk(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 1'($urandom_range(0, 1)));
        end else begin
          s = rand_unit();
        end
        send_sample(s);
        // Sender waits until every result is back
        if (ph == 4 && k == 60) begin
          sample_ch.valid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/isa_pkg.sv
rtl/isa_if.sv
rtl/isa_front.sv
rtl/isa_fifo.sv
rtl/isa_back.sv
rtl/imu_sagittal_angle_core.sv
sim/tb_imu_sagittal_angle_core.sv
